// ===== rtl/stxq_pkg.sv =====
package stxq_pkg;

  // Request codes carried in req_type
  localparam logic [2:0] REQ_PACKET_BYTE  = 3'd0;
  localparam logic [2:0] REQ_STREAM       = 3'd1;
  localparam logic [2:0] REQ_START_RESULT = 3'd2;
  localparam logic [2:0] REQ_TX_DONE      = 3'd3;
  localparam logic [2:0] REQ_TX_ERROR     = 3'd4;
  localparam logic [2:0] REQ_SERVICE      = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_TOO_LONG = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_NO_REQ   = 3'd4;

  // Result action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_STREAM = 2'd2;

  localparam logic [5:0] MAX_BYTES_RESET = 6'd32;

  typedef enum logic [1:0] {
    OWN_NONE   = 2'd0,
    OWN_CMD    = 2'd1,
    OWN_STREAM = 2'd2
  } own_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_FIRST,
    S_PUT
  } ctl_state_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] stream_length;
    logic        start_ok;
    logic [7:0]  error_code;
    logic        transmitter_ready;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  action;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] stream_length_out;
    own_t        owner;
    logic [2:0]  queued_packets;
    logic [31:0] drop_count;
    logic [31:0] start_error_count;
    logic [31:0] stream_error_count;
    logic [31:0] complete_count;
    logic [7:0]  last_error;
  } rsp_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic len_rd;
    logic emit_start;
    logic load_one;
    logic load_byte;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/stxq_in_if.sv =====
interface stxq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [15:0] stream_length;
  logic        start_ok;
  logic [7:0]  error_code;
  logic        transmitter_ready;

  modport source (
    output valid, req_type, data_byte, last_byte, stream_length, start_ok,
           error_code, transmitter_ready,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, last_byte, stream_length, start_ok,
           error_code, transmitter_ready,
    output ready
  );
endinterface

// ===== rtl/stxq_out_if.sv =====
interface stxq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  action;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [15:0] stream_length_out;
  logic [1:0]  owner;
  logic [2:0]  queued_packets;
  logic [31:0] drop_count;
  logic [31:0] start_error_count;
  logic [31:0] stream_error_count;
  logic [31:0] complete_count;
  logic [7:0]  last_error;

  modport source (
    output valid, status, action, tx_byte, tx_last, stream_length_out, owner,
           queued_packets, drop_count, start_error_count, stream_error_count,
           complete_count, last_error,
    input  ready
  );
  modport sink (
    input  valid, status, action, tx_byte, tx_last, stream_length_out, owner,
           queued_packets, drop_count, start_error_count, stream_error_count,
           complete_count, last_error,
    output ready
  );
endinterface

// ===== rtl/stxq_cfg_if.sv =====
interface stxq_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/shared_tx_packet_queue_arbiter.sv =====
// Shared transmit arbiter: one transmitter serves a ring queue of short command
// packets and bulk stream transfers.
// Channels: req (sink) carries one request beat per item; rsp (source) returns
// one result beat per item, or one beat per packet byte when a queued packet is
// started; cfg (sink) writes max_packet_bytes and is always ready.
// After acceptance, req stays not ready until the request's results are loaded. A
// request that yields one result loads its beat into the output register; a
// request that starts a packet first reads the length table, then the byte store,
// then makes one store read per emitted byte. Each result beat is registered in
// the output register once rsp is free to take it.
// Reset (rst, synchronous) empties the queue, releases the owner, clears all
// counters and sets max_packet_bytes to 32; the byte store and length table
// are not cleared and need no clearing pass.
// When rsp stalls, hold the current result beat in the output register; the
// block still accepts one more request, then waits with req not ready until
// that request's results can be loaded.
module shared_tx_packet_queue_arbiter #(
  parameter int QUEUE_SLOTS  = 8,
  parameter int PACKET_BYTES = 32
) (
  input logic        clk,
  input logic        rst,
  stxq_in_if.sink    req,
  stxq_out_if.source rsp,
  stxq_cfg_if.sink   cfg
);
  import stxq_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  req_item_t in_item;
  rsp_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  // Gather the request beat into one word for the datapath
  assign in_item.req_type          = req.req_type;
  assign in_item.data_byte         = req.data_byte;
  assign in_item.last_byte         = req.last_byte;
  assign in_item.stream_length     = req.stream_length;
  assign in_item.start_ok          = req.start_ok;
  assign in_item.error_code        = req.error_code;
  assign in_item.transmitter_ready = req.transmitter_ready;
  assign req.ready                 = in_ready;

  // Register writes must only arrive while idle; the block does not enforce this and takes them at once
  assign cfg.ready = 1'b1;

  stxq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stxq_datapath #(
    .QUEUE_SLOTS  (QUEUE_SLOTS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .cfg_we    (cfg.valid),
    .cfg_data  (cfg.data),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (rsp.ready)
  );

  // Drive the result beat straight from the output register
  assign rsp.valid              = out_valid;
  assign rsp.status             = out_item.status;
  assign rsp.action             = out_item.action;
  assign rsp.tx_byte            = out_item.tx_byte;
  assign rsp.tx_last            = out_item.tx_last;
  assign rsp.stream_length_out  = out_item.stream_length_out;
  assign rsp.owner              = out_item.owner;
  assign rsp.queued_packets     = out_item.queued_packets;
  assign rsp.drop_count         = out_item.drop_count;
  assign rsp.start_error_count  = out_item.start_error_count;
  assign rsp.stream_error_count = out_item.stream_error_count;
  assign rsp.complete_count     = out_item.complete_count;
  assign rsp.last_error         = out_item.last_error;

endmodule

// ===== rtl/stxq_ctrl.sv =====
module stxq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  stxq_pkg::dp_stat_t stat,
  output stxq_pkg::dp_cmd_t  cmd
);
  import stxq_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_ONE;
      end
      S_ONE: begin
        if (stat.emit) state_next = S_FIRST;
        else if (stat.out_free) state_next = S_IDLE;
      end
      S_FIRST: state_next = S_PUT;
      S_PUT: begin
        if (stat.out_free && stat.last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_ONE: begin
        cmd.len_rd   = stat.emit;
        cmd.load_one = !stat.emit && stat.out_free;
      end
      S_FIRST: cmd.emit_start = 1'b1;
      S_PUT:   cmd.load_byte  = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/stxq_datapath.sv =====
module stxq_datapath #(
  parameter int QUEUE_SLOTS  = 8,
  parameter int PACKET_BYTES = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  stxq_pkg::dp_cmd_t   cmd,
  output stxq_pkg::dp_stat_t  stat,
  input  stxq_pkg::req_item_t in_item,
  input  logic                cfg_we,
  input  logic [5:0]          cfg_data,
  output stxq_pkg::rsp_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready
);
  import stxq_pkg::*;

  localparam int SW    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int LW    = $clog2(PACKET_BYTES + 1);
  localparam int DEPTH = QUEUE_SLOTS * PACKET_BYTES;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    store [DEPTH];
  logic [LW-1:0] lengths [QUEUE_SLOTS];

  logic [SW-1:0] head, tail, head_n, tail_n;
  logic [LW-1:0] fill, fill_n, fill_inc;
  logic          too_long, too_long_n;
  own_t          owner, owner_n, pending, pending_n;
  logic [31:0]   drops, drops_n, start_errs, start_errs_n;
  logic [31:0]   stream_errs, stream_errs_n, completes, completes_n;
  logic [7:0]    last_err, last_err_n;
  logic [5:0]    max_bytes;

  logic [2:0]    status_q, status_n;
  logic [1:0]    action_q, action_n;
  logic [15:0]   slen_q, slen_n;
  logic          emit_q, emit_n;
  logic          st_we, len_we, kick_en;

  logic [6:0]    lim7;
  logic [LW-1:0] lim;
  logic [6:0]    q7;

  logic [LW-1:0] len_rd_q, len_clamped, len_q, idx, idx_inc;
  logic [7:0]    byte_rd;
  logic          rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          last;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  // Effective packet limit from the register
  always_comb begin
    if (max_bytes == 6'd0) lim7 = 7'd1;
    else if ({1'b0, max_bytes} > 7'(PACKET_BYTES)) lim7 = 7'(PACKET_BYTES);
    else lim7 = {1'b0, max_bytes};
  end
  assign lim      = lim7[LW-1:0];
  assign fill_inc = fill + 1'b1;

  always_comb begin
    head_n        = head;
    tail_n        = tail;
    fill_n        = fill;
    too_long_n    = too_long;
    owner_n       = owner;
    pending_n     = pending;
    drops_n       = drops;
    start_errs_n  = start_errs;
    stream_errs_n = stream_errs;
    completes_n   = completes;
    last_err_n    = last_err;
    status_n      = ST_NO_REQ;
    action_n      = ACT_NONE;
    slen_n        = '0;
    emit_n        = 1'b0;
    st_we         = 1'b0;
    len_we        = 1'b0;
    kick_en       = 1'b0;
    case (in_item.req_type)
      REQ_PACKET_BYTE: begin
        status_n = ST_OK;
        if (fill < lim) begin
          st_we  = 1'b1;
          fill_n = fill_inc;
        end else begin
          too_long_n = 1'b1;
        end
        if (in_item.last_byte) begin
          if (too_long_n) begin
            status_n = ST_TOO_LONG;
          end else if (next_slot(head) == tail) begin
            status_n = ST_FULL;
            drops_n  = drops + 32'd1;
          end else begin
            len_we  = 1'b1;
            head_n  = next_slot(head);
            kick_en = 1'b1;
          end
          fill_n     = '0;
          too_long_n = 1'b0;
        end
      end
      REQ_STREAM: begin
        if (in_item.stream_length == 16'd0 || owner != OWN_NONE || head != tail) begin
          status_n = ST_REFUSED;
        end else begin
          status_n  = ST_OK;
          owner_n   = OWN_STREAM;
          pending_n = OWN_STREAM;
          action_n  = ACT_STREAM;
          slen_n    = in_item.stream_length;
        end
      end
      REQ_START_RESULT: begin
        if (!in_item.start_ok) begin
          if (pending == OWN_CMD) begin
            owner_n      = OWN_NONE;
            start_errs_n = start_errs + 32'd1;
          end else if (pending == OWN_STREAM) begin
            if (owner == OWN_STREAM) owner_n = OWN_NONE;
            stream_errs_n = stream_errs + 32'd1;
          end
        end
        pending_n = OWN_NONE;
      end
      REQ_TX_DONE: begin
        if (owner == OWN_CMD) begin
          tail_n      = next_slot(tail);
          owner_n     = OWN_NONE;
          pending_n   = OWN_NONE;
          completes_n = completes + 32'd1;
        end else if (owner == OWN_STREAM) begin
          owner_n   = OWN_NONE;
          pending_n = OWN_NONE;
        end
        kick_en = 1'b1;
      end
      REQ_TX_ERROR: begin
        last_err_n = in_item.error_code;
        if (owner == OWN_STREAM && in_item.transmitter_ready) begin
          owner_n       = OWN_NONE;
          pending_n     = OWN_NONE;
          stream_errs_n = stream_errs + 32'd1;
        end
      end
      REQ_SERVICE: kick_en = 1'b1;
      default: ;
    endcase
    // Start the oldest packet when the transmitter is free
    if (kick_en && owner_n == OWN_NONE && head_n != tail_n) begin
      owner_n   = OWN_CMD;
      pending_n = OWN_CMD;
      emit_n    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      fill        <= '0;
      too_long    <= 1'b0;
      owner       <= OWN_NONE;
      pending     <= OWN_NONE;
      drops       <= '0;
      start_errs  <= '0;
      stream_errs <= '0;
      completes   <= '0;
      last_err    <= '0;
      max_bytes   <= MAX_BYTES_RESET;
      emit_q      <= 1'b0;
    end else begin
      if (cfg_we) max_bytes <= cfg_data;
      if (cmd.accept) begin
        head        <= head_n;
        tail        <= tail_n;
        fill        <= fill_n;
        too_long    <= too_long_n;
        owner       <= owner_n;
        pending     <= pending_n;
        drops       <= drops_n;
        start_errs  <= start_errs_n;
        stream_errs <= stream_errs_n;
        completes   <= completes_n;
        last_err    <= last_err_n;
        emit_q      <= emit_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_q <= status_n;
      action_q <= action_n;
      slen_q   <= slen_n;
    end
  end

  // Packet byte store and length table
  assign wr_addr = AW'(int'(head) * PACKET_BYTES + int'(fill));

  always_ff @(posedge clk) begin
    if (cmd.accept && st_we) store[wr_addr] <= in_item.data_byte;
    if (rd_en) byte_rd <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && len_we) lengths[head] <= fill_n == '0 ? fill_inc : fill_inc;
    if (cmd.len_rd) len_rd_q <= lengths[tail];
  end

  // Emission walk over the packet at the tail slot
  always_comb begin
    if (len_rd_q == '0) len_clamped = LW'(1);
    else if (len_rd_q > LW'(PACKET_BYTES)) len_clamped = LW'(PACKET_BYTES);
    else len_clamped = len_rd_q;
  end

  assign idx_inc = idx + 1'b1;
  assign last    = (idx_inc == len_q);
  assign rd_en   = cmd.emit_start || (cmd.load_byte && !last);
  assign rd_addr = cmd.emit_start ? AW'(int'(tail) * PACKET_BYTES)
                                  : AW'(int'(tail) * PACKET_BYTES + int'(idx_inc));

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      len_q <= len_clamped;
      idx   <= '0;
    end else if (cmd.load_byte && !last) begin
      idx <= idx_inc;
    end
  end

  // Output register
  assign q7 = (head >= tail) ? 7'(head) - 7'(tail)
                             : 7'(head) + 7'(QUEUE_SLOTS) - 7'(tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_one || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_one || cmd.load_byte) begin
      out_item.status             <= status_q;
      out_item.action             <= cmd.load_byte ? ACT_BYTE : action_q;
      out_item.tx_byte            <= cmd.load_byte ? byte_rd : 8'd0;
      out_item.tx_last            <= cmd.load_byte ? last : 1'b1;
      out_item.stream_length_out  <= slen_q;
      out_item.owner              <= owner;
      out_item.queued_packets     <= q7[2:0];
      out_item.drop_count         <= drops;
      out_item.start_error_count  <= start_errs;
      out_item.stream_error_count <= stream_errs;
      out_item.complete_count     <= completes;
      out_item.last_error         <= last_err;
    end
  end

  assign stat.emit     = emit_q;
  assign stat.last     = last;
  assign stat.out_free = !out_valid || out_ready;

endmodule
